FILE: sv/stepper_driver_uart_datagram_engine_core_defines.svh
// assertion macros shared by the datagram engine modules
`ifndef STEPPER_DRIVER_UART_DATAGRAM_ENGINE_CORE_DEFINES_SVH
`define STEPPER_DRIVER_UART_DATAGRAM_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SDUE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SDUE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/sdue_pkg.sv
`timescale 1ns / 1ps

package sdue_pkg;

    // input item codes
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_REPLY = 2'd2
    } t_action;

    // work handed from front to back
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_REJECT = 2'd2,
        CMD_DONE   = 2'd3
    } t_cmd_op;

    // result kinds
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DONE   = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CRC  = 2'd1;
    localparam logic [1:0] ST_HDR  = 2'd2;
    localparam logic [1:0] ST_AXIS = 2'd3;

    // datagram constants
    localparam logic [7:0] SYNC_BYTE  = 8'h05;
    localparam logic [7:0] WRITE_NODE = 8'h00;
    localparam logic [7:0] WRITE_FLAG = 8'h80;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    // command queue geometry
    localparam int CQ_DEPTH = 4;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    typedef struct packed {
        t_cmd_op     op;
        logic [3:0]  axis;
        logic [6:0]  reg_addr;
        logic [7:0]  node;
        logic [31:0] data;
        logic [1:0]  status;
    } t_cmd;

    // crc8 over one byte, bits taken lsb first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] c;
        logic       fb;
        c = crc_in;
        for (int k = 0; k < 8; k++) begin
            fb = c[7] ^ data_in[k];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return c;
    endfunction

endpackage

FILE: sv/sdue_front.sv
`timescale 1ns / 1ps

module sdue_front #(
    parameter int NUM_AXES = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_action,
    input  logic [3:0]        i_axis,
    input  logic [6:0]        i_reg_addr,
    input  logic [31:0]       i_write_data,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_cfg_wr_en,
    input  logic [7:0]        i_cfg_wr_data,
    output logic              o_q_push,
    output sdue_pkg::t_cmd    o_q_cmd
);

    logic [7:0]  r_node_addr;
    logic        r_pending, n_pending;
    logic [6:0]  r_pend_reg, n_pend_reg;
    logic [3:0]  r_pend_axis, n_pend_axis;
    logic [2:0]  r_count, n_count;
    logic [7:0]  r_rx_crc, n_rx_crc;
    logic        r_sync_ok, n_sync_ok;
    logic        r_reg_ok, n_reg_ok;
    logic [31:0] r_rx_data, n_rx_data;
    logic        axis_bad;

    assign axis_bad = ({1'b0, i_axis} >= 5'(NUM_AXES));

    // classify the item and update the reply collector
    always_comb begin
        n_pending   = r_pending;
        n_pend_reg  = r_pend_reg;
        n_pend_axis = r_pend_axis;
        n_count     = r_count;
        n_rx_crc    = r_rx_crc;
        n_sync_ok   = r_sync_ok;
        n_reg_ok    = r_reg_ok;
        n_rx_data   = r_rx_data;
        o_q_push    = 1'b0;
        o_q_cmd     = '{op: sdue_pkg::CMD_REJECT, axis: i_axis, reg_addr: i_reg_addr,
                        node: r_node_addr, data: '0, status: sdue_pkg::ST_OK};
        if (i_accept) begin
            unique case (sdue_pkg::t_action'(i_action)) inside
                sdue_pkg::ACT_WRITE, sdue_pkg::ACT_READ: begin
                    o_q_push = 1'b1;
                    if (axis_bad) begin
                        o_q_cmd.op     = sdue_pkg::CMD_REJECT;
                        o_q_cmd.status = sdue_pkg::ST_AXIS;
                    end else if (sdue_pkg::t_action'(i_action) == sdue_pkg::ACT_WRITE) begin
                        o_q_cmd.op   = sdue_pkg::CMD_WRITE;
                        o_q_cmd.node = sdue_pkg::WRITE_NODE;
                        o_q_cmd.data = i_write_data;
                    end else begin
                        // arm the collector, dropping any partial reply
                        o_q_cmd.op  = sdue_pkg::CMD_READ;
                        n_pending   = 1'b1;
                        n_pend_reg  = i_reg_addr;
                        n_pend_axis = i_axis;
                        n_count     = 3'd0;
                        n_rx_crc    = 8'h00;
                    end
                end
                sdue_pkg::ACT_REPLY: begin
                    if (r_pending) begin
                        if (r_count != 3'd7) begin
                            n_rx_crc  = sdue_pkg::crc8_byte(r_rx_crc, i_rx_byte);
                            n_rx_data = {r_rx_data[23:0], i_rx_byte};
                            n_count   = r_count + 3'd1;
                            if (r_count == 3'd0) begin
                                n_sync_ok = (i_rx_byte == sdue_pkg::SYNC_BYTE);
                            end
                            if (r_count == 3'd2) begin
                                n_reg_ok = (i_rx_byte == {1'b0, r_pend_reg});
                            end
                        end else begin
                            // eighth byte: check and report
                            o_q_push     = 1'b1;
                            o_q_cmd.op   = sdue_pkg::CMD_DONE;
                            o_q_cmd.axis = r_pend_axis;
                            if (r_rx_crc != i_rx_byte) begin
                                o_q_cmd.status = sdue_pkg::ST_CRC;
                            end else if (!(r_sync_ok && r_reg_ok)) begin
                                o_q_cmd.status = sdue_pkg::ST_HDR;
                            end else begin
                                o_q_cmd.status = sdue_pkg::ST_OK;
                                o_q_cmd.data   = r_rx_data;
                            end
                            n_pending = 1'b0;
                            n_count   = 3'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_addr <= 8'h00;
            r_pending   <= 1'b0;
            r_pend_reg  <= 7'd0;
            r_pend_axis <= 4'd0;
            r_count     <= 3'd0;
            r_rx_crc    <= 8'h00;
        end else begin
            if (i_cfg_wr_en) begin
                r_node_addr <= i_cfg_wr_data;
            end
            r_pending   <= n_pending;
            r_pend_reg  <= n_pend_reg;
            r_pend_axis <= n_pend_axis;
            r_count     <= n_count;
            r_rx_crc    <= n_rx_crc;
        end
    end

    // reply payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_sync_ok <= n_sync_ok;
        r_reg_ok  <= n_reg_ok;
        r_rx_data <= n_rx_data;
    end

endmodule

FILE: sv/sdue_cmdq.sv
`timescale 1ns / 1ps
`include "stepper_driver_uart_datagram_engine_core_defines.svh"

module sdue_cmdq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sdue_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output sdue_pkg::t_cmd o_head
);

    sdue_pkg::t_cmd                r_mem [sdue_pkg::CQ_DEPTH];
    logic [sdue_pkg::CQ_AW-1:0]    r_wr_ptr;
    logic [sdue_pkg::CQ_AW-1:0]    r_rd_ptr;
    logic [sdue_pkg::CQ_CW-1:0]    r_count;

    assign o_full  = (r_count == sdue_pkg::CQ_CW'(sdue_pkg::CQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `SDUE_ASSERT_NOW(a_cq_level, i_clk, i_rst_n, 1'b1, r_count <= sdue_pkg::CQ_CW'(sdue_pkg::CQ_DEPTH), "command queue level out of range")
    `SDUE_ASSERT_NOW(a_cq_no_overflow, i_clk, i_rst_n, i_push, !o_full || i_pop, "command queue written while full")
    `SDUE_ASSERT_NOW(a_cq_no_underflow, i_clk, i_rst_n, i_pop, !o_empty, "command queue read while empty")

endmodule

FILE: sv/sdue_back.sv
`timescale 1ns / 1ps
`include "stepper_driver_uart_datagram_engine_core_defines.svh"

module sdue_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_empty,
    input  sdue_pkg::t_cmd i_q_head,
    output logic           o_q_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_tx_byte,
    output logic           o_last,
    output logic [3:0]     o_out_axis,
    output logic [31:0]    o_read_data,
    output logic [1:0]     o_status
);

    logic        r_o_valid;
    logic [1:0]  r_o_kind;
    logic [7:0]  r_o_tx_byte;
    logic        r_o_last;
    logic [3:0]  r_o_axis;
    logic [31:0] r_o_data;
    logic [1:0]  r_o_status;
    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_crc, n_crc;
    logic        load;
    logic        cmd_end;
    logic [1:0]  beat_kind;
    logic [7:0]  beat_byte;
    logic        beat_last;
    logic [31:0] beat_data;
    logic [1:0]  beat_status;

    assign load    = (!r_o_valid || i_pop) && !i_q_empty;
    assign o_q_pop = load && cmd_end;
    assign o_empty = !r_o_valid;

    assign o_kind      = r_o_kind;
    assign o_tx_byte   = r_o_tx_byte;
    assign o_last      = r_o_last;
    assign o_out_axis  = r_o_axis;
    assign o_read_data = r_o_data;
    assign o_status    = r_o_status;

    // pick the next beat of the head command
    always_comb begin
        beat_kind   = sdue_pkg::KIND_TX;
        beat_byte   = 8'h00;
        beat_last   = 1'b0;
        beat_data   = '0;
        beat_status = sdue_pkg::ST_OK;
        cmd_end     = 1'b1;
        unique case (i_q_head.op)
            sdue_pkg::CMD_WRITE: begin
                cmd_end   = (r_idx == 3'd7);
                beat_last = cmd_end;
                case (r_idx)
                    3'd0:    beat_byte = sdue_pkg::SYNC_BYTE;
                    3'd1:    beat_byte = i_q_head.node;
                    3'd2:    beat_byte = sdue_pkg::WRITE_FLAG | {1'b0, i_q_head.reg_addr};
                    3'd3:    beat_byte = i_q_head.data[31:24];
                    3'd4:    beat_byte = i_q_head.data[23:16];
                    3'd5:    beat_byte = i_q_head.data[15:8];
                    3'd6:    beat_byte = i_q_head.data[7:0];
                    default: beat_byte = r_crc;
                endcase
            end
            sdue_pkg::CMD_READ: begin
                cmd_end   = (r_idx == 3'd3);
                beat_last = cmd_end;
                case (r_idx)
                    3'd0:    beat_byte = sdue_pkg::SYNC_BYTE;
                    3'd1:    beat_byte = i_q_head.node;
                    3'd2:    beat_byte = {1'b0, i_q_head.reg_addr};
                    default: beat_byte = r_crc;
                endcase
            end
            sdue_pkg::CMD_REJECT: begin
                beat_kind   = sdue_pkg::KIND_REJECT;
                beat_status = i_q_head.status;
            end
            sdue_pkg::CMD_DONE: begin
                beat_kind   = sdue_pkg::KIND_DONE;
                beat_data   = i_q_head.data;
                beat_status = i_q_head.status;
            end
            default: begin
            end
        endcase
    end

    // beat counter and running crc
    always_comb begin
        n_idx = r_idx;
        n_crc = r_crc;
        if (load) begin
            if (cmd_end) begin
                n_idx = 3'd0;
                n_crc = 8'h00;
            end else begin
                n_idx = r_idx + 3'd1;
                n_crc = sdue_pkg::crc8_byte(r_crc, beat_byte);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_idx     <= 3'd0;
            r_crc     <= 8'h00;
        end else begin
            r_idx <= n_idx;
            r_crc <= n_crc;
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_pop) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_kind    <= beat_kind;
            r_o_tx_byte <= beat_byte;
            r_o_last    <= beat_last;
            r_o_axis    <= i_q_head.axis;
            r_o_data    <= beat_data;
            r_o_status  <= beat_status;
        end
    end

    `SDUE_ASSERT_NOW(a_bk_last_resets, i_clk, i_rst_n, r_o_valid && r_o_last, r_idx == 3'd0 && r_crc == 8'h00, "beat counter not cleared after last byte")
    `SDUE_ASSERT_NOW(a_bk_single_beat, i_clk, i_rst_n, r_o_valid && r_o_kind != sdue_pkg::KIND_TX, r_idx == 3'd0 && !r_o_last && r_o_tx_byte == 8'h00, "report beat inside a datagram")

endmodule

FILE: sv/stepper_driver_uart_datagram_engine_core.sv
`timescale 1ns / 1ps

// channel   | handshake           | payload
// ----------+---------------------+-------------------------------------------------
// request   | push / full         | i_action i_axis i_reg_addr i_write_data i_rx_byte
// result    | empty / pop         | o_kind o_tx_byte o_last o_out_axis o_read_data o_status
// config    | i_cfg_wr_en         | i_cfg_wr_data (read node address)
//
// one result beat per cycle while pop keeps up: a write gives 8 beats at the output,
// a read 4, a reject or a read completion 1; a reply byte with no result gives none.
// the output beat generator sets the rate; a 4-entry command queue lets the
// front keep accepting items while the back still streams a datagram.
// reset is synchronous and active low, with no clearing pass.
// full rises only while the command queue holds four commands.
module stepper_driver_uart_datagram_engine_core #(
    parameter int NUM_AXES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [3:0]  i_axis,
    input  logic [6:0]  i_reg_addr,
    input  logic [31:0] i_write_data,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last,
    output logic [3:0]  o_out_axis,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_status,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data
);

    logic           in_accept;
    logic           q_push;
    logic           q_pop;
    logic           q_empty;
    sdue_pkg::t_cmd q_cmd;
    sdue_pkg::t_cmd q_head;

    assign in_accept = push && !full;

    // classify requests and collect replies
    sdue_front #(
        .NUM_AXES (NUM_AXES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_action      (i_action),
        .i_axis        (i_axis),
        .i_reg_addr    (i_reg_addr),
        .i_write_data  (i_write_data),
        .i_rx_byte     (i_rx_byte),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_q_push      (q_push),
        .o_q_cmd       (q_cmd)
    );

    // commands waiting for the beat generator
    sdue_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // expand commands into result beats
    sdue_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_kind      (o_kind),
        .o_tx_byte   (o_tx_byte),
        .o_last      (o_last),
        .o_out_axis  (o_out_axis),
        .o_read_data (o_read_data),
        .o_status    (o_status)
    );

endmodule
